// ===== hdl/multichannel_trimmed_mean_filter_top_assert.svh =====
// Assertion macros shared by the checker of the trimmed mean filter.
`ifndef MULTICHANNEL_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH
`define MULTICHANNEL_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MCTMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MCTMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mctmf_pkg.sv =====
// Package with types and constants of the multichannel trimmed mean filter.
`timescale 1ns / 1ps

package mctmf_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int CHAN_W       = 2;
  localparam int SAMPLE_W     = 12;
  localparam int VALUE_W      = 13;
  localparam int SUM_W        = 16;
  localparam int COUNT_W      = 4;
  localparam int MID_SHIFT    = 3;
  localparam int AVG_W        = 12;
  localparam int RECIP_W      = 25;
  localparam int RECIP_SHIFT  = 24;
  localparam int PROD_W       = AVG_W + RECIP_W;
  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_W    = $clog2(JOB_DEPTH);

  localparam logic [COUNT_W-1:0]  WINDOW     = COUNT_W'(10);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = 13'd5000;

  // The scale 1000/819 as a fixed-point factor rounded up, exact for every average.
  localparam logic [RECIP_W-1:0]  SCALE_RECIP = 25'd20485002;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel_out;
    logic [VALUE_W-1:0] value;
  } out_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
  } job_t;

endpackage

// ===== hdl/multichannel_trimmed_mean_filter_top.sv =====
// Top level of the multichannel trimmed mean filter.
//
//   Channel   Direction  Handshake            Beat
//   samples   in         push_i / full_o      in_beat_i  (channel, sample)
//   results   out        pop_i / empty_o      out_beat_o (channel_out, value)
//
// One sample beat is taken per cycle while full_o is low and updates its channel's
// statistics in that cycle; a tenth one queues a job, registered in avg_q, prod_q and out_q.
// The four-entry job queue raises full_o when full, which only result stalls can cause.
// While full_o is high, every sample beat waits, not only a tenth one.
// Reset returns every channel's count, sum, minimum and maximum to their start values.
`timescale 1ns / 1ps

module multichannel_trimmed_mean_filter_top #(
  parameter int CHANNELS = mctmf_pkg::CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  mctmf_pkg::in_beat_t  in_beat_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output mctmf_pkg::out_beat_t out_beat_o
);

  logic            accept;
  logic            job_push;
  mctmf_pkg::job_t job_in;
  mctmf_pkg::job_t job_out;
  logic            job_empty;
  logic            job_pop;

  assign accept = push_i && !full_o;

  mctmf_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_beat_i (in_beat_i),
    .job_push_o(job_push),
    .job_o     (job_in)
  );

  mctmf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (full_o),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  mctmf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_beat_o (out_beat_o)
  );

endmodule

// ===== hdl/mctmf_front.sv =====
// Front end: per-channel statistics update and window completion detection.
`timescale 1ns / 1ps

module mctmf_front #(
  parameter int CHANNELS = mctmf_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  mctmf_pkg::in_beat_t in_beat_i,
  output logic               job_push_o,
  output mctmf_pkg::job_t    job_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [mctmf_pkg::COUNT_W-1:0]  count_q [CHANNELS];
  logic [mctmf_pkg::SUM_W-1:0]    sum_q   [CHANNELS];
  logic [mctmf_pkg::SAMPLE_W-1:0] min_q   [CHANNELS];
  logic [mctmf_pkg::SAMPLE_W-1:0] max_q   [CHANNELS];

  logic [CH_W-1:0]                idx;
  logic                           in_range;
  logic                           update;
  logic                           fire;
  logic [mctmf_pkg::COUNT_W-1:0]  count_d;
  logic [mctmf_pkg::SUM_W-1:0]    sum_d;
  logic [mctmf_pkg::SAMPLE_W-1:0] min_d;
  logic [mctmf_pkg::SAMPLE_W-1:0] max_d;

  always_comb begin
    idx      = CH_W'(in_beat_i.channel);
    in_range = (32'(in_beat_i.channel) < CHANNELS);
    update   = accept_i && in_range;
    count_d  = count_q[idx] + mctmf_pkg::COUNT_W'(1);
    sum_d    = sum_q[idx] + mctmf_pkg::SUM_W'(in_beat_i.sample);
    min_d    = (in_beat_i.sample < min_q[idx]) ? in_beat_i.sample : min_q[idx];
    max_d    = (in_beat_i.sample > max_q[idx]) ? in_beat_i.sample : max_q[idx];
    fire     = (count_d == mctmf_pkg::WINDOW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        count_q[c] <= '0;
        sum_q[c]   <= '0;
        min_q[c]   <= mctmf_pkg::SAMPLE_MAX;
        max_q[c]   <= '0;
      end
    end else if (update) begin
      if (fire) begin
        count_q[idx] <= '0;
        sum_q[idx]   <= '0;
        min_q[idx]   <= mctmf_pkg::SAMPLE_MAX;
        max_q[idx]   <= '0;
      end else begin
        count_q[idx] <= count_d;
        sum_q[idx]   <= sum_d;
        min_q[idx]   <= min_d;
        max_q[idx]   <= max_d;
      end
    end
  end

  assign job_push_o    = update && fire;
  assign job_o.channel = in_beat_i.channel;
  assign job_o.sum     = sum_d;
  assign job_o.min     = min_d;
  assign job_o.max     = max_d;

endmodule

// ===== hdl/mctmf_fifo.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module mctmf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mctmf_pkg::job_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mctmf_pkg::job_t data_o,
  output logic            empty_o
);

  mctmf_pkg::job_t                  mem_q [mctmf_pkg::JOB_DEPTH];
  logic [mctmf_pkg::JOB_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mctmf_pkg::JOB_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [mctmf_pkg::JOB_PTR_W:0]    fill_q, fill_d;
  logic                             do_push;
  logic                             do_pop;

  always_comb begin
    full_o   = (fill_q == (mctmf_pkg::JOB_PTR_W+1)'(mctmf_pkg::JOB_DEPTH));
    empty_o  = (fill_q == '0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + mctmf_pkg::JOB_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + mctmf_pkg::JOB_PTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q + (mctmf_pkg::JOB_PTR_W+1)'(do_push)
                      - (mctmf_pkg::JOB_PTR_W+1)'(do_pop);
    data_o   = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mctmf_back.sv =====
// Back end: trimmed average, reciprocal scaling and the result register.
`timescale 1ns / 1ps

module mctmf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  mctmf_pkg::job_t      job_i,
  output logic                 job_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output mctmf_pkg::out_beat_t out_beat_o
);

  logic                             avg_v_q, avg_v_d;
  logic [mctmf_pkg::CHAN_W-1:0]     avg_ch_q;
  logic [mctmf_pkg::AVG_W-1:0]      avg_q;
  logic                             prod_v_q, prod_v_d;
  logic [mctmf_pkg::CHAN_W-1:0]     prod_ch_q;
  logic [mctmf_pkg::PROD_W-1:0]     prod_q;
  logic                             out_v_q, out_v_d;
  mctmf_pkg::out_beat_t             out_q;

  logic                             out_ready;
  logic                             prod_ready;
  logic                             avg_ready;
  logic [mctmf_pkg::SUM_W-1:0]      trimmed;
  logic [mctmf_pkg::PROD_W-1:0]     prod;

  always_comb begin
    out_ready  = !out_v_q || pop_i;
    prod_ready = !prod_v_q || out_ready;
    avg_ready  = !avg_v_q || prod_ready;
    job_pop_o  = job_valid_i && avg_ready;

    // Ten real samples always hold the minimum and the maximum in separate slots.
    trimmed = job_i.sum - mctmf_pkg::SUM_W'(job_i.min) - mctmf_pkg::SUM_W'(job_i.max);
    prod    = mctmf_pkg::PROD_W'(avg_q) * mctmf_pkg::PROD_W'(mctmf_pkg::SCALE_RECIP);

    avg_v_d  = avg_ready ? job_valid_i : avg_v_q;
    prod_v_d = prod_ready ? avg_v_q : prod_v_q;
    out_v_d  = out_ready ? prod_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      avg_v_q  <= avg_v_d;
      prod_v_q <= prod_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      avg_ch_q <= job_i.channel;
      avg_q    <= trimmed[mctmf_pkg::MID_SHIFT +: mctmf_pkg::AVG_W];
    end
    if (prod_ready && avg_v_q) begin
      prod_ch_q <= avg_ch_q;
      prod_q    <= prod;
    end
    if (out_ready && prod_v_q) begin
      out_q.channel_out <= prod_ch_q;
      out_q.value       <= prod_q[mctmf_pkg::RECIP_SHIFT +: mctmf_pkg::VALUE_W];
    end
  end

  assign empty_o    = !out_v_q;
  assign out_beat_o = out_q;

endmodule

// ===== hdl/mctmf_checker.sv =====
// Port-level checker of the trimmed mean filter and its binding.
`timescale 1ns / 1ps
`include "multichannel_trimmed_mean_filter_top_assert.svh"

module mctmf_checker #(
  parameter int CHANNELS = mctmf_pkg::CHANNELS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 pop_i,
  input logic                 empty_o,
  input mctmf_pkg::out_beat_t out_beat_o
);

  `MCTMF_ASSERT_NEXT(a_result_held, !empty_o && !pop_i, !empty_o && $stable(out_beat_o), "result beat changed while stalled")
  `MCTMF_ASSERT_IMP(a_channel_range, !empty_o, 32'(out_beat_o.channel_out) < CHANNELS, "result for a channel that does not exist")
  `MCTMF_ASSERT_IMP(a_value_range, !empty_o, out_beat_o.value <= mctmf_pkg::VALUE_MAX, "result value above full scale")

endmodule

bind multichannel_trimmed_mean_filter_top mctmf_checker #(
  .CHANNELS(CHANNELS)
) u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .pop_i     (pop_i),
  .empty_o   (empty_o),
  .out_beat_o(out_beat_o)
);

// ===== tb/sv/tb_multichannel_trimmed_mean_filter_top.sv =====
// Self-checking testbench for the multichannel trimmed mean filter under random flow control.
`timescale 1ns / 1ps

module tb_multichannel_trimmed_mean_filter_top;
  import mctmf_pkg::*;

  localparam int MEAN_SCALE_NUM = 1000;
  localparam int MEAN_SCALE_DEN = 819;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 430;

  class trimmed_mean_board;
    logic [COUNT_W-1:0]  run_count [CHANNELS_DEF];
    logic [SUM_W-1:0]    run_total [CHANNELS_DEF];
    logic [SAMPLE_W-1:0] run_low   [CHANNELS_DEF];
    logic [SAMPLE_W-1:0] run_high  [CHANNELS_DEF];
    out_beat_t           expected_means[$];
    int unsigned         errors;

    function new();
      errors = 0;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        clear_channel(c);
      end
    endfunction

    function void clear_channel(int c);
      run_count[c] = '0;
      run_total[c] = '0;
      run_low[c]   = SAMPLE_MAX;
      run_high[c]  = '0;
    endfunction

    function void absorb_sample(in_beat_t b);
      int unsigned ch;
      int unsigned trimmed;
      out_beat_t   r;
      ch = b.channel;
      if (ch >= CHANNELS_DEF) return;
      run_total[ch] = run_total[ch] + SUM_W'(b.sample);
      if (b.sample < run_low[ch]) run_low[ch] = b.sample;
      if (b.sample > run_high[ch]) run_high[ch] = b.sample;
      run_count[ch] = run_count[ch] + 1'b1;
      if (run_count[ch] < WINDOW) return;
      trimmed = int'(run_total[ch]) - int'(run_low[ch]) - int'(run_high[ch]);
      r.channel_out = CHAN_W'(ch);
      r.value = VALUE_W'(((trimmed >> MID_SHIFT) * MEAN_SCALE_NUM) / MEAN_SCALE_DEN);
      expected_means.push_back(r);
      clear_channel(ch);
    endfunction

    function void check_mean(out_beat_t r);
      out_beat_t e;
      if (expected_means.size() == 0) begin
        $error("unexpected result beat: channel_out %0d value %0d", r.channel_out, r.value);
        errors++;
        return;
      end
      e = expected_means.pop_front();
      if (r.channel_out !== e.channel_out) begin
        $error("channel_out expected %0d actual %0d", e.channel_out, r.channel_out);
        errors++;
      end
      if (r.value !== e.value) begin
        $error("value expected %0d actual %0d", e.value, r.value);
        errors++;
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push_i;
  logic      full_o;
  in_beat_t  in_beat_i;
  logic      pop_i = 1'b0;
  logic      empty_o;
  out_beat_t out_beat_o;

  trimmed_mean_board board;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       phase_no;
  logic              hold_results = 1'b0;
  int unsigned       quiet_cycles = 0;
  int unsigned       last_channel;
  int                level_base [CHANNELS_DEF];

  multichannel_trimmed_mean_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_beat_i  (in_beat_i),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_beat_o (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop_i <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) board.absorb_sample(in_beat_i);
    if (rst_ni && pop_i && !empty_o) board.check_mean(out_beat_o);
    if ((push_i && !full_o) || (pop_i && !empty_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    wait (phase_no == 2);
    @(posedge clk_i);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_results <= 1'b0;
  end

  task automatic send_sample(int unsigned ch, int unsigned smp);
    in_beat_t b;
    b.channel = CHAN_W'(ch);
    b.sample  = SAMPLE_W'(smp);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  task automatic send_directed();
    for (int i = 0; i < 10; i++) begin
      send_sample(0, (i == 3) ? 0 : SAMPLE_MAX);
      send_sample(1, (i == 6) ? SAMPLE_MAX : 0);
    end
    send_sample(2, 2048);
    send_sample(3, 1);
    send_sample(2, 1365);
    send_sample(3, 2730);
  endtask

  task automatic send_random(int n);
    int unsigned ch;
    int          v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) last_channel = $urandom_range(CHANNELS_DEF - 1);
      ch = last_channel;
      if ($urandom_range(49) == 0) level_base[ch] = $urandom_range(SAMPLE_MAX);
      case ($urandom_range(9))
        0: v = 0;
        1: v = SAMPLE_MAX;
        2, 3, 4: begin
          v = level_base[ch] + int'($urandom_range(30)) - 15;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end
        default: v = $urandom_range(SAMPLE_MAX);
      endcase
      send_sample(ch, v);
    end
  endtask

  initial begin
    board         = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_no      = 0;
    last_channel  = 0;
    for (int c = 0; c < CHANNELS_DEF; c++) level_base[c] = $urandom_range(SAMPLE_MAX);
    rst_ni       <= 1'b0;
    push_i       <= 1'b0;
    in_beat_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();

    send_idle_pct = 8;
    recv_idle_pct = 70;
    send_random(PHASE_ITEMS);

    phase_no      = 1;
    send_idle_pct = 70;
    recv_idle_pct = 8;
    send_random(PHASE_ITEMS);

    phase_no      = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PHASE_ITEMS);

    push_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== multichannel_trimmed_mean_filter_top.f =====
+incdir+hdl
hdl/mctmf_pkg.sv
hdl/mctmf_front.sv
hdl/mctmf_fifo.sv
hdl/mctmf_back.sv
hdl/multichannel_trimmed_mean_filter_top.sv
hdl/mctmf_checker.sv
tb/sv/tb_multichannel_trimmed_mean_filter_top.sv
